// ===== sv/lsbp_pkg.sv =====
// lsbp_pkg: shared types and constants for the link supervisor.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package lsbp_pkg;

  // Supervisor modes, as reported on the result channel
  typedef enum logic [2:0] {
    MODE_OFF        = 3'd0,
    MODE_SCANNING   = 3'd1,
    MODE_PORTAL     = 3'd2,
    MODE_CONNECTING = 3'd3,
    MODE_ONLINE     = 3'd4,
    MODE_FAILED     = 3'd5
  } mode_t;

  // Request opcodes
  typedef enum logic [2:0] {
    OP_TICK       = 3'd0,
    OP_DISCONNECT = 3'd1,
    OP_BEGIN      = 3'd2,
    OP_SAVE       = 3'd3,
    OP_FORGET     = 3'd4,
    OP_PORTAL_REQ = 3'd5
  } op_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_CONNECT_TIMEOUT = 3'd0,
    REG_RETRY_FIRST     = 3'd1,
    REG_RETRY_MAX       = 3'd2,
    REG_FAIL_LIMIT      = 3'd3,
    REG_SCAN_PERIOD     = 3'd4,
    REG_CLOSE_DELAY     = 3'd5,
    REG_IDLE_LIMIT      = 3'd6
  } reg_idx_t;

  localparam int unsigned MS_W   = 24;
  localparam int unsigned FAIL_W = 8;

  localparam logic [MS_W-1:0]   RST_CONNECT_TIMEOUT = 24'd20000;
  localparam logic [MS_W-1:0]   RST_RETRY_FIRST     = 24'd3000;
  localparam logic [MS_W-1:0]   RST_RETRY_MAX       = 24'd30000;
  localparam logic [FAIL_W-1:0] RST_FAIL_LIMIT      = 8'd4;
  localparam logic [MS_W-1:0]   RST_SCAN_PERIOD     = 24'd30000;
  localparam logic [MS_W-1:0]   RST_CLOSE_DELAY     = 24'd1500;
  localparam logic [MS_W-1:0]   RST_IDLE_LIMIT      = 24'd300000;
  localparam logic [FAIL_W-1:0] FAIL_SAT            = 8'hFF;

  // Configuration register set
  typedef struct packed {
    logic [MS_W-1:0]   connect_timeout;
    logic [MS_W-1:0]   retry_first;
    logic [MS_W-1:0]   retry_max;
    logic [FAIL_W-1:0] fail_limit;
    logic [MS_W-1:0]   scan_period;
    logic [MS_W-1:0]   close_delay;
    logic [MS_W-1:0]   idle_limit;
  } cfg_t;

  // Non-timestamp supervisor state
  typedef struct packed {
    mode_t             mode;
    logic [MS_W-1:0]   retry_delay;
    logic [FAIL_W-1:0] failures;
    logic              scan_running;
    logic              close_armed;
    logic              portal_by_user;
    logic              have_creds;
    logic              disconnect_pending;
  } ctl_t;

  // One-cycle commands
  typedef struct packed {
    logic join_cmd;
    logic drop_cmd;
    logic open_cmd;
    logic close_cmd;
    logic scan_cmd;
  } cmd_t;

endpackage

`default_nettype wire

// ===== sv/lsbp_cfg_regs.sv =====
// lsbp_cfg_regs: configuration register file of the link supervisor.
// Depends on lsbp_pkg (cfg_t, register indexes, reset values).
`timescale 1ns / 1ps
`default_nettype none

module lsbp_cfg_regs (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_we,
  input  wire logic [2:0]               cfg_index,
  input  wire logic [lsbp_pkg::MS_W-1:0] cfg_data,
  output lsbp_pkg::cfg_t                cfg
);

  lsbp_pkg::cfg_t cfg_r;

  // Register writes, one register per write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.connect_timeout <= lsbp_pkg::RST_CONNECT_TIMEOUT;
      cfg_r.retry_first     <= lsbp_pkg::RST_RETRY_FIRST;
      cfg_r.retry_max       <= lsbp_pkg::RST_RETRY_MAX;
      cfg_r.fail_limit      <= lsbp_pkg::RST_FAIL_LIMIT;
      cfg_r.scan_period     <= lsbp_pkg::RST_SCAN_PERIOD;
      cfg_r.close_delay     <= lsbp_pkg::RST_CLOSE_DELAY;
      cfg_r.idle_limit      <= lsbp_pkg::RST_IDLE_LIMIT;
    end else if (cfg_we) begin
      case (lsbp_pkg::reg_idx_t'(cfg_index))
        lsbp_pkg::REG_CONNECT_TIMEOUT: cfg_r.connect_timeout <= cfg_data;
        lsbp_pkg::REG_RETRY_FIRST:     cfg_r.retry_first     <= cfg_data;
        lsbp_pkg::REG_RETRY_MAX:       cfg_r.retry_max       <= cfg_data;
        lsbp_pkg::REG_FAIL_LIMIT:      cfg_r.fail_limit      <= cfg_data[lsbp_pkg::FAIL_W-1:0];
        lsbp_pkg::REG_SCAN_PERIOD:     cfg_r.scan_period     <= cfg_data;
        lsbp_pkg::REG_CLOSE_DELAY:     cfg_r.close_delay     <= cfg_data;
        lsbp_pkg::REG_IDLE_LIMIT:      cfg_r.idle_limit      <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ===== sv/lsbp_step.sv =====
// lsbp_step: next-state and command logic for one request.
// Depends on lsbp_pkg (mode_t, op_t, cfg_t, ctl_t, cmd_t).
`timescale 1ns / 1ps
`default_nettype none

module lsbp_step #(
  parameter int unsigned TIME_BITS = 32
) (
  input  wire logic [2:0]           op,
  input  wire logic [TIME_BITS-1:0] now,
  input  wire logic                 associated,
  input  wire logic                 has_address,
  input  wire logic                 ap_client,
  input  wire logic                 scan_done,
  input  wire logic                 creds_present,
  input  wire lsbp_pkg::cfg_t       cfg,
  input  wire lsbp_pkg::ctl_t       ctl_cur,
  input  wire logic [TIME_BITS-1:0] attempt_start_cur,
  input  wire logic [TIME_BITS-1:0] next_attempt_cur,
  input  wire logic [TIME_BITS-1:0] last_scan_cur,
  input  wire logic [TIME_BITS-1:0] close_at_cur,
  input  wire logic [TIME_BITS-1:0] opened_at_cur,
  output lsbp_pkg::ctl_t            ctl_nxt,
  output logic [TIME_BITS-1:0]      attempt_start_nxt,
  output logic [TIME_BITS-1:0]      next_attempt_nxt,
  output logic [TIME_BITS-1:0]      last_scan_nxt,
  output logic [TIME_BITS-1:0]      close_at_nxt,
  output logic [TIME_BITS-1:0]      opened_at_nxt,
  output lsbp_pkg::cmd_t            cmd
);

  // compare width: wide enough for timestamps and 24-bit intervals
  localparam int unsigned CW = (TIME_BITS > lsbp_pkg::MS_W) ? TIME_BITS : lsbp_pkg::MS_W;

  logic [TIME_BITS-1:0]        retry_at;     // now + retry delay
  logic [TIME_BITS-1:0]        close_at_new; // now + close delay
  logic [TIME_BITS-1:0]        d_close, d_next, d_retry;
  logic [TIME_BITS-1:0]        el_attempt, el_opened, el_scan;
  logic                        close_due, next_due, retry_due;
  logic                        timeout_hit, idle_hit, scan_hit;
  logic [lsbp_pkg::MS_W:0]     dbl_w;
  logic [lsbp_pkg::MS_W-1:0]   dbl;
  logic [lsbp_pkg::FAIL_W-1:0] fail_inc;
  logic                        portal_up;

  lsbp_pkg::mode_t m;
  logic            sr;
  logic            stop;
  logic            retry_set;
  logic            do_fail, do_restart, do_begin, do_open, do_scan, by_user;

  // deadline sums and elapsed times
  assign retry_at     = TIME_BITS'(CW'(now) + CW'(ctl_cur.retry_delay));
  assign close_at_new = TIME_BITS'(CW'(now) + CW'(cfg.close_delay));
  assign d_close      = now - close_at_cur;
  assign d_next       = now - next_attempt_cur;
  assign d_retry      = now - retry_at;
  assign close_due    = !d_close[TIME_BITS-1];
  assign next_due     = !d_next[TIME_BITS-1];
  assign retry_due    = !d_retry[TIME_BITS-1];
  assign el_attempt   = now - attempt_start_cur;
  assign el_opened    = now - opened_at_cur;
  assign el_scan      = now - last_scan_cur;
  assign timeout_hit  = CW'(el_attempt) >= CW'(cfg.connect_timeout);
  assign idle_hit     = CW'(el_opened) >= CW'(cfg.idle_limit);
  assign scan_hit     = CW'(el_scan) >= CW'(cfg.scan_period);

  // backoff doubling with ceiling, saturating failure count
  assign dbl_w    = {ctl_cur.retry_delay, 1'b0};
  assign dbl      = (dbl_w > {1'b0, cfg.retry_max}) ? cfg.retry_max
                                                    : dbl_w[lsbp_pkg::MS_W-1:0];
  assign fail_inc = (ctl_cur.failures == lsbp_pkg::FAIL_SAT) ? lsbp_pkg::FAIL_SAT
                                                             : ctl_cur.failures + 8'd1;
  assign portal_up = (ctl_cur.mode == lsbp_pkg::MODE_SCANNING) ||
                     (ctl_cur.mode == lsbp_pkg::MODE_PORTAL);

  // decide actions, then apply them in order
  always_comb begin
    ctl_nxt           = ctl_cur;
    attempt_start_nxt = attempt_start_cur;
    next_attempt_nxt  = next_attempt_cur;
    last_scan_nxt     = last_scan_cur;
    close_at_nxt      = close_at_cur;
    opened_at_nxt     = opened_at_cur;
    cmd        = '0;
    m          = ctl_cur.mode;
    sr         = ctl_cur.scan_running;
    stop       = 1'b0;
    retry_set  = 1'b0;
    do_fail    = 1'b0;
    do_restart = 1'b0;
    do_begin   = 1'b0;
    do_open    = 1'b0;
    do_scan    = 1'b0;
    by_user    = 1'b0;

    case (lsbp_pkg::op_t'(op))
      lsbp_pkg::OP_TICK: begin
        if (ctl_cur.mode != lsbp_pkg::MODE_OFF) begin
          if (sr && scan_done) begin
            sr = 1'b0;
            if (m == lsbp_pkg::MODE_SCANNING) m = lsbp_pkg::MODE_PORTAL;
          end
          // pending disconnect is handled ahead of the mode logic
          if (ctl_cur.disconnect_pending && m != lsbp_pkg::MODE_FAILED) begin
            ctl_nxt.disconnect_pending = 1'b0;
            if (m == lsbp_pkg::MODE_ONLINE) begin
              m         = lsbp_pkg::MODE_FAILED;
              retry_set = 1'b1;
            end else if (m == lsbp_pkg::MODE_CONNECTING) begin
              do_fail = 1'b1;
              stop    = 1'b1;
            end
          end
          if (!stop) begin
            case (m)
              lsbp_pkg::MODE_SCANNING, lsbp_pkg::MODE_PORTAL: begin
                if (ctl_cur.close_armed && close_due) begin
                  ctl_nxt.close_armed = 1'b0;
                  cmd.close_cmd       = 1'b1;
                  do_restart          = 1'b1;
                  do_begin            = 1'b1;
                end else if (ctl_cur.have_creds && !ctl_cur.portal_by_user &&
                             !ap_client && idle_hit) begin
                  cmd.close_cmd = 1'b1;
                  do_restart    = 1'b1;
                  do_begin      = 1'b1;
                end else if (!sr && !ap_client && scan_hit) begin
                  do_scan = 1'b1;
                end
              end
              lsbp_pkg::MODE_CONNECTING: begin
                if (associated && has_address) begin
                  m          = lsbp_pkg::MODE_ONLINE;
                  do_restart = 1'b1;
                end else if (timeout_hit) begin
                  do_fail = 1'b1;
                end
              end
              lsbp_pkg::MODE_ONLINE: begin
                if (!associated) begin
                  m         = lsbp_pkg::MODE_FAILED;
                  retry_set = 1'b1;
                end
              end
              lsbp_pkg::MODE_FAILED: begin
                // deadline may have been set earlier in this same tick
                if (ctl_cur.have_creds && (retry_set ? retry_due : next_due))
                  do_begin = 1'b1;
              end
              default: ;
            endcase
          end
        end
      end
      lsbp_pkg::OP_DISCONNECT: begin
        ctl_nxt.disconnect_pending = 1'b1;
      end
      lsbp_pkg::OP_BEGIN: begin
        ctl_nxt.have_creds = creds_present;
        if (creds_present) begin
          cmd.close_cmd = portal_up;
          do_begin      = 1'b1;
        end else begin
          do_open = 1'b1;
        end
      end
      lsbp_pkg::OP_SAVE: begin
        if (portal_up) begin
          ctl_nxt.have_creds  = 1'b1;
          ctl_nxt.close_armed = 1'b1;
          close_at_nxt        = close_at_new;
        end
      end
      lsbp_pkg::OP_FORGET: begin
        ctl_nxt.have_creds = 1'b0;
        cmd.drop_cmd       = 1'b1;
        do_restart         = 1'b1;
        do_open            = 1'b1;
      end
      lsbp_pkg::OP_PORTAL_REQ: begin
        if (!portal_up) begin
          cmd.drop_cmd = 1'b1;
          do_restart   = 1'b1;
          do_open      = 1'b1;
          by_user      = 1'b1;
        end
      end
      default: ;
    endcase

    ctl_nxt.mode         = m;
    ctl_nxt.scan_running = sr;
    if (retry_set) next_attempt_nxt = retry_at;

    // failed attempt: count, drop, schedule retry, maybe fall back to portal
    if (do_fail) begin
      ctl_nxt.failures    = fail_inc;
      ctl_nxt.mode        = lsbp_pkg::MODE_FAILED;
      cmd.drop_cmd        = 1'b1;
      next_attempt_nxt    = retry_at;
      ctl_nxt.retry_delay = dbl;
      if (fail_inc >= cfg.fail_limit) begin
        do_restart = 1'b1;
        do_open    = 1'b1;
      end
    end

    if (do_restart) begin
      ctl_nxt.failures    = '0;
      ctl_nxt.retry_delay = cfg.retry_first;
    end

    if (do_begin) begin
      cmd.join_cmd               = 1'b1;
      ctl_nxt.mode               = lsbp_pkg::MODE_CONNECTING;
      attempt_start_nxt          = now;
      ctl_nxt.disconnect_pending = 1'b0;
    end

    if (do_open) begin
      cmd.open_cmd           = 1'b1;
      ctl_nxt.mode           = lsbp_pkg::MODE_SCANNING;
      opened_at_nxt          = now;
      ctl_nxt.portal_by_user = by_user;
      if (!sr) do_scan = 1'b1;
    end

    // scan start, a no-op while one is running
    if (do_scan) begin
      ctl_nxt.scan_running = 1'b1;
      last_scan_nxt        = now;
      cmd.scan_cmd         = 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== sv/link_supervisor_backoff_portal.sv =====
// link_supervisor_backoff_portal: top level of the connection supervisor.
// Depends on lsbp_pkg, lsbp_cfg_regs and lsbp_step.
//
// Every request (tick or event) yields exactly one result carrying the mode and
// one-cycle commands. A request is taken into an input register, runs through
// the step logic, and lands in the result register together with the state
// update, so throughput is one request per cycle while out_stall stays low;
// out_valid is raised with the result register. Result-side stall holds the
// result register and backs up into in_stall once the input register is full.
// Timestamps are TIME_BITS wide; deadlines use wrap-safe differences.
// Configuration writes take effect on the next cycle and belong in idle periods.
`timescale 1ns / 1ps
`default_nettype none

module link_supervisor_backoff_portal #(
  parameter int unsigned TIME_BITS = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // configuration port
  input  wire logic                         cfg_we,
  input  wire logic [2:0]                   cfg_index,
  input  wire logic [lsbp_pkg::MS_W-1:0]    cfg_data,
  // request channel
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [2:0]                   in_op,
  input  wire logic [31:0]                  in_now_ms,
  input  wire logic                         in_associated,
  input  wire logic                         in_has_address,
  input  wire logic                         in_ap_client,
  input  wire logic                         in_scan_done,
  input  wire logic                         in_creds_present,
  // result channel
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [2:0]                        out_link_mode,
  output logic                              out_join_cmd,
  output logic                              out_drop_link_cmd,
  output logic                              out_portal_open_cmd,
  output logic                              out_portal_close_cmd,
  output logic                              out_scan_cmd,
  output logic [lsbp_pkg::FAIL_W-1:0]       out_failure_count,
  output logic [lsbp_pkg::MS_W-1:0]         out_retry_delay_ms
);

  lsbp_pkg::cfg_t cfg;

  // input register
  logic        s1_valid_r, s1_valid_nxt;
  logic [2:0]  s1_op_r;
  logic [31:0] s1_now_r;
  logic        s1_assoc_r, s1_addr_r, s1_client_r, s1_done_r, s1_creds_r;

  // supervisor state
  lsbp_pkg::ctl_t       ctl_r, ctl_nxt;
  logic [TIME_BITS-1:0] attempt_start_r, attempt_start_nxt;
  logic [TIME_BITS-1:0] next_attempt_r, next_attempt_nxt;
  logic [TIME_BITS-1:0] last_scan_r, last_scan_nxt;
  logic [TIME_BITS-1:0] close_at_r, close_at_nxt;
  logic [TIME_BITS-1:0] opened_at_r, opened_at_nxt;
  logic [TIME_BITS-1:0] now_w;

  // result register
  logic                        out_valid_r, out_valid_nxt;
  lsbp_pkg::cmd_t              cmd, out_cmd_r;
  lsbp_pkg::mode_t             out_mode_r;
  logic [lsbp_pkg::FAIL_W-1:0] out_fail_r;
  logic [lsbp_pkg::MS_W-1:0]   out_delay_r;

  logic advance;
  logic take_in;

  lsbp_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // handshake: the input register drains whenever the result slot frees up
  assign advance      = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall     = s1_valid_r && !advance;
  assign take_in      = in_valid && !in_stall;
  assign s1_valid_nxt = take_in ? 1'b1 : (advance ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = advance ? 1'b1 : (out_stall ? out_valid_r : 1'b0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // request payload capture
  always_ff @(posedge clk) begin
    if (take_in) begin
      s1_op_r     <= in_op;
      s1_now_r    <= in_now_ms;
      s1_assoc_r  <= in_associated;
      s1_addr_r   <= in_has_address;
      s1_client_r <= in_ap_client;
      s1_done_r   <= in_scan_done;
      s1_creds_r  <= in_creds_present;
    end
  end

  assign now_w = TIME_BITS'(s1_now_r);

  lsbp_step #(
    .TIME_BITS (TIME_BITS)
  ) u_step (
    .op                (s1_op_r),
    .now               (now_w),
    .associated        (s1_assoc_r),
    .has_address       (s1_addr_r),
    .ap_client         (s1_client_r),
    .scan_done         (s1_done_r),
    .creds_present     (s1_creds_r),
    .cfg               (cfg),
    .ctl_cur           (ctl_r),
    .attempt_start_cur (attempt_start_r),
    .next_attempt_cur  (next_attempt_r),
    .last_scan_cur     (last_scan_r),
    .close_at_cur      (close_at_r),
    .opened_at_cur     (opened_at_r),
    .ctl_nxt           (ctl_nxt),
    .attempt_start_nxt (attempt_start_nxt),
    .next_attempt_nxt  (next_attempt_nxt),
    .last_scan_nxt     (last_scan_nxt),
    .close_at_nxt      (close_at_nxt),
    .opened_at_nxt     (opened_at_nxt),
    .cmd               (cmd)
  );

  // state update, once per request that moves to the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.mode               <= lsbp_pkg::MODE_OFF;
      ctl_r.retry_delay        <= lsbp_pkg::RST_RETRY_FIRST;
      ctl_r.failures           <= '0;
      ctl_r.scan_running       <= 1'b0;
      ctl_r.close_armed        <= 1'b0;
      ctl_r.portal_by_user     <= 1'b0;
      ctl_r.have_creds         <= 1'b0;
      ctl_r.disconnect_pending <= 1'b0;
      attempt_start_r          <= '0;
      next_attempt_r           <= '0;
      last_scan_r              <= '0;
      close_at_r               <= '0;
      opened_at_r              <= '0;
    end else if (advance) begin
      ctl_r           <= ctl_nxt;
      attempt_start_r <= attempt_start_nxt;
      next_attempt_r  <= next_attempt_nxt;
      last_scan_r     <= last_scan_nxt;
      close_at_r      <= close_at_nxt;
      opened_at_r     <= opened_at_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (advance) begin
      out_mode_r  <= ctl_nxt.mode;
      out_cmd_r   <= cmd;
      out_fail_r  <= ctl_nxt.failures;
      out_delay_r <= ctl_nxt.retry_delay;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_link_mode        = out_mode_r;
  assign out_join_cmd         = out_cmd_r.join_cmd;
  assign out_drop_link_cmd    = out_cmd_r.drop_cmd;
  assign out_portal_open_cmd  = out_cmd_r.open_cmd;
  assign out_portal_close_cmd = out_cmd_r.close_cmd;
  assign out_scan_cmd         = out_cmd_r.scan_cmd;
  assign out_failure_count    = out_fail_r;
  assign out_retry_delay_ms   = out_delay_r;

  // a join always leaves the supervisor connecting
  a_join_mode : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_cmd_r.join_cmd |-> out_mode_r == lsbp_pkg::MODE_CONNECTING)
    else $error("join command without connecting mode");

  // opening the portal always lands in scanning
  a_open_mode : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_cmd_r.open_cmd |-> out_mode_r == lsbp_pkg::MODE_SCANNING)
    else $error("portal open command without scanning mode");

  // back-pressure only when the input register is occupied
  a_stall_full : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("request stalled with empty input register");

  // state moves only with a request
  a_state_hold : assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(ctl_r) && $stable(next_attempt_r))
    else $error("supervisor state changed without a request");

endmodule

`default_nettype wire
